// ----- rtl/dkt_pkg.sv -----
package dkt_pkg;

    localparam int ACTION_W      = 2;
    localparam int ID_W          = 16;
    localparam int KEY_W         = 2 * ID_W;
    localparam int START_SLOT_W  = 10;
    localparam int ENTRY_INDEX_W = 9;
    localparam int BIN_NUMBER_W  = 9;
    localparam int STATUS_W      = 3;
    localparam int BINS_USED_W   = 10;

    localparam int TABLE_SLOTS_DEFAULT = 1024;
    localparam int MAX_BINS_DEFAULT    = 512;

    localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_ALT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd5;

    typedef struct packed {
        logic                load;
        logic                h_zero;
        logic                reduce;
        logic                slot_rd;
        logic                advance;
        logic                insert;
        logic                sweep;
        logic                dense_rd;
        logic                clear_count;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
    } cmd_t;

    typedef struct packed {
        logic h_in_range;
        logic occupied;
        logic key_match;
        logic bins_full;
        logic last_probe;
        logic sweep_last;
    } stat_t;

endpackage

// ----- rtl/dkt_ram.sv -----
module dkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/dkt_ctrl.sv -----
module dkt_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [dkt_pkg::ACTION_W-1:0]    action,
    output logic                            busy,
    output dkt_pkg::cmd_t                   cmd,
    input  dkt_pkg::stat_t                  st
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_REDUCE   = 3'd2;
    localparam logic [2:0] S_PROBE    = 3'd3;
    localparam logic [2:0] S_CLEAR    = 3'd4;
    localparam logic [2:0] S_READ     = 3'd5;
    localparam logic [2:0] S_READ_OUT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (action) inside
                        dkt_pkg::ACT_READ, dkt_pkg::ACT_READ_ALT:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_READ;
                        end
                        dkt_pkg::ACT_CLEAR:
                        begin
                            cmd.h_zero = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_REDUCE;
                        end
                    endcase
                end
            end
            S_REDUCE:
            begin
                if (!st.h_in_range)
                begin
                    cmd.reduce = 1'b1;
                end
                else
                begin
                    cmd.slot_rd = 1'b1;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!st.occupied)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (st.bins_full)
                    begin
                        cmd.emit_status = dkt_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        cmd.insert      = 1'b1;
                        cmd.emit_status = dkt_pkg::ST_INSERTED;
                    end
                end
                else if (st.key_match)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = dkt_pkg::ST_FOUND;
                    state_next      = S_IDLE;
                end
                else if (st.last_probe)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = dkt_pkg::ST_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (st.sweep_last)
                begin
                    cmd.clear_count = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = dkt_pkg::ST_CLEARED;
                    state_next      = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.dense_rd = 1'b1;
                state_next   = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = dkt_pkg::ST_READ;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// ----- rtl/dkt_datapath.sv -----
module dkt_datapath #(
    parameter int TABLE_SLOTS = dkt_pkg::TABLE_SLOTS_DEFAULT,
    parameter int MAX_BINS    = dkt_pkg::MAX_BINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dkt_pkg::cmd_t                       cmd,
    output dkt_pkg::stat_t                      st,
    input  logic [dkt_pkg::ID_W-1:0]            mesh_id,
    input  logic [dkt_pkg::ID_W-1:0]            material_id,
    input  logic [dkt_pkg::START_SLOT_W-1:0]    start_slot,
    input  logic [dkt_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    output logic                                done,
    output logic [dkt_pkg::BIN_NUMBER_W-1:0]    bin_number,
    output logic [dkt_pkg::STATUS_W-1:0]        status,
    output logic [dkt_pkg::BINS_USED_W-1:0]     bins_used,
    output logic [dkt_pkg::ID_W-1:0]            entry_mesh,
    output logic [dkt_pkg::ID_W-1:0]            entry_material,
    output logic                                entry_valid
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int BIN_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W   = $clog2(MAX_BINS + 1);
    localparam int START_W = dkt_pkg::START_SLOT_W;
    localparam int H_W     = (START_W > SLOT_W) ? START_W : SLOT_W;
    localparam int KEY_W   = dkt_pkg::KEY_W;
    localparam int ID_W    = dkt_pkg::ID_W;
    localparam int IDX_W   = dkt_pkg::ENTRY_INDEX_W;
    localparam int SWORD_W = 1 + KEY_W + BIN_W;
    localparam int BNUM_W  = dkt_pkg::BIN_NUMBER_W;
    localparam int BUSED_W = dkt_pkg::BINS_USED_W;

    logic [H_W-1:0]     h_reg;
    logic [H_W-1:0]     h_next;
    logic [SLOT_W-1:0]  probe_reg;
    logic [SLOT_W-1:0]  probe_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [KEY_W-1:0]   key_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               done_reg;

    logic [BNUM_W-1:0]                bin_number_reg;
    logic [dkt_pkg::STATUS_W-1:0]     status_reg;
    logic [BUSED_W-1:0]               bins_used_reg;
    logic [ID_W-1:0]                  entry_mesh_reg;
    logic [ID_W-1:0]                  entry_material_reg;
    logic                             entry_valid_reg;

    logic [SLOT_W-1:0]  slot_idx;
    logic [SLOT_W-1:0]  h_inc;
    logic [SLOT_W-1:0]  slot_raddr;
    logic [SWORD_W-1:0] slot_wdata;
    logic [SWORD_W-1:0] slot_rdata;
    logic [KEY_W-1:0]   dense_rdata;
    logic [KEY_W-1:0]   slot_key;
    logic [BIN_W-1:0]   slot_bin;
    logic               entry_ok;
    logic [BNUM_W-1:0]  bin_out;

    assign slot_idx = h_reg[SLOT_W-1:0];
    assign h_inc    = (slot_idx == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_idx + SLOT_W'(1);
    assign slot_key = slot_rdata[BIN_W +: KEY_W];
    assign slot_bin = slot_rdata[BIN_W-1:0];

    assign st.h_in_range = (32'(h_reg) < 32'(TABLE_SLOTS));
    assign st.occupied   = slot_rdata[SWORD_W-1];
    assign st.key_match  = (slot_key == key_reg);
    assign st.bins_full  = (cnt_reg == CNT_W'(MAX_BINS));
    assign st.last_probe = (probe_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign st.sweep_last = (slot_idx == SLOT_W'(TABLE_SLOTS - 1));

    always_comb
    begin
        h_next = h_reg;
        if (cmd.load)
        begin
            h_next = H_W'(start_slot);
        end
        else if (cmd.h_zero)
        begin
            h_next = '0;
        end
        else if (cmd.reduce)
        begin
            h_next = h_reg - H_W'(TABLE_SLOTS);
        end
        else if (cmd.advance || cmd.sweep)
        begin
            h_next = H_W'(h_inc);
        end
    end

    always_comb
    begin
        probe_next = probe_reg;
        if (cmd.load)
        begin
            probe_next = '0;
        end
        else if (cmd.advance)
        begin
            probe_next = probe_reg + SLOT_W'(1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clear_count)
        begin
            cnt_next = '0;
        end
        else if (cmd.insert)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign entry_ok = (cmd.emit_status == dkt_pkg::ST_READ)
                      && (32'(idx_reg) < 32'(cnt_reg))
                      && (32'(idx_reg) < 32'(MAX_BINS));

    always_comb
    begin
        case (cmd.emit_status)
            dkt_pkg::ST_FOUND:    bin_out = BNUM_W'(slot_bin);
            dkt_pkg::ST_INSERTED: bin_out = BNUM_W'(cnt_reg);
            default:              bin_out = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= '0;
            probe_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            h_reg     <= h_next;
            probe_reg <= probe_next;
            cnt_reg   <= cnt_next;
            done_reg  <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= {mesh_id, material_id};
            idx_reg <= entry_index;
        end
        if (cmd.emit)
        begin
            bin_number_reg     <= bin_out;
            status_reg         <= cmd.emit_status;
            bins_used_reg      <= BUSED_W'(cnt_next);
            entry_valid_reg    <= entry_ok;
            entry_mesh_reg     <= entry_ok ? dense_rdata[KEY_W-1:ID_W] : '0;
            entry_material_reg <= entry_ok ? dense_rdata[ID_W-1:0] : '0;
        end
    end

    assign slot_raddr = cmd.advance ? h_inc : slot_idx;
    assign slot_wdata = cmd.sweep ? '0 : {1'b1, key_reg, cnt_reg[BIN_W-1:0]};

    dkt_ram #(
        .WIDTH (SWORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.insert | cmd.sweep),
        .waddr (slot_idx),
        .wdata (slot_wdata),
        .re    (cmd.slot_rd | cmd.advance),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    dkt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_BINS)
    ) u_dense_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (cnt_reg[BIN_W-1:0]),
        .wdata (key_reg),
        .re    (cmd.dense_rd),
        .raddr (BIN_W'(idx_reg)),
        .rdata (dense_rdata)
    );

    assign done           = done_reg;
    assign bin_number     = bin_number_reg;
    assign status         = status_reg;
    assign bins_used      = bins_used_reg;
    assign entry_mesh     = entry_mesh_reg;
    assign entry_material = entry_material_reg;
    assign entry_valid    = entry_valid_reg;

    a_insert_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (!st.occupied && !st.bins_full))
        else $error("Insert into an occupied slot or past the last bin.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("Result strobe held for more than one cycle.");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(MAX_BINS))
        else $error("Bin count beyond the number of bins.");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == dkt_pkg::ST_CLEARED)) |-> (bins_used_reg == '0))
        else $error("Clear reported a nonzero bin count.");

endmodule

// ----- rtl/draw_bin_key_dedup_table.sv -----
// Maps (mesh, material) keys to dense bin numbers in first-seen order using an
// open-addressed table with linear probing from a caller-supplied start slot.
// A word is accepted when start is high and busy is low, and each word yields
// exactly one result word, shown for a single cycle with done high; the
// receiver cannot stall, so it must take the result in that cycle. A register
// word first reduces its start slot, subtracting TABLE_SLOTS until it is in
// range, then reads the slot memory once per cycle from there, wrapping at
// the end, until it finds an empty slot, a matching key or has made its
// last probe. A read word reads the dense memory and then shows the entry. A
// clear word walks the slot memory one entry per cycle and zeroes the count.
// After reset the same pass runs with busy high.
module draw_bin_key_dedup_table #(
    parameter int TABLE_SLOTS = dkt_pkg::TABLE_SLOTS_DEFAULT,
    parameter int MAX_BINS    = dkt_pkg::MAX_BINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dkt_pkg::ACTION_W-1:0]        action,
    input  logic [dkt_pkg::ID_W-1:0]            mesh_id,
    input  logic [dkt_pkg::ID_W-1:0]            material_id,
    input  logic [dkt_pkg::START_SLOT_W-1:0]    start_slot,
    input  logic [dkt_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    output logic                                done,
    output logic [dkt_pkg::BIN_NUMBER_W-1:0]    bin_number,
    output logic [dkt_pkg::STATUS_W-1:0]        status,
    output logic [dkt_pkg::BINS_USED_W-1:0]     bins_used,
    output logic [dkt_pkg::ID_W-1:0]            entry_mesh,
    output logic [dkt_pkg::ID_W-1:0]            entry_material,
    output logic                                entry_valid
);

    dkt_pkg::cmd_t  cmd;
    dkt_pkg::stat_t st;

    dkt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd),
        .st     (st)
    );

    dkt_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_BINS    (MAX_BINS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .mesh_id        (mesh_id),
        .material_id    (material_id),
        .start_slot     (start_slot),
        .entry_index    (entry_index),
        .done           (done),
        .bin_number     (bin_number),
        .status         (status),
        .bins_used      (bins_used),
        .entry_mesh     (entry_mesh),
        .entry_material (entry_material),
        .entry_valid    (entry_valid)
    );

endmodule
